// ----- sv/slmc_pkg.sv -----
// shared types, constants and helpers for the standardized linear / mlp classifier
// no dependencies
package slmc_pkg;

  localparam int FEATURES     = 8;
  localparam int HIDDEN_UNITS = 16;
  localparam int COEF_DEPTH   = 256;

  localparam int COEF_AW  = $clog2(COEF_DEPTH);
  localparam int FEAT_DEPTH = 16;
  localparam int FEAT_AW  = 4;
  localparam int STD_AW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int HID_AW   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int MAX_TERMS = (FEATURES > HIDDEN_UNITS) ? FEATURES : HIDDEN_UNITS;
  localparam int KW       = $clog2(MAX_TERMS + 1);

  // coefficient map
  localparam int A_MEAN  = 0;
  localparam int A_SCALE = FEATURES;
  localparam int A_SVM_W = 2 * FEATURES;
  localparam int A_SVM_B = 3 * FEATURES;
  localparam int A_LDA_W = 3 * FEATURES + 1;
  localparam int A_LDA_B = 4 * FEATURES + 1;
  localparam int A_W0    = 4 * FEATURES + 2;
  localparam int A_B0    = A_W0 + FEATURES * HIDDEN_UNITS;
  localparam int A_W1    = A_B0 + HIDDEN_UNITS;
  localparam int A_B1    = A_W1 + HIDDEN_UNITS;

  // configuration
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNK_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAINED   = 3'd4;

  localparam logic [1:0] MODE_SVM  = 2'd0;
  localparam logic [1:0] MODE_LDA  = 2'd1;
  localparam logic [1:0] MODE_MLP  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic OP_COEF = 1'b0;
  localparam logic OP_FEAT = 1'b1;

  localparam logic [1:0] INTENT_LEFT    = 2'd0;
  localparam logic [1:0] INTENT_RIGHT   = 2'd1;
  localparam logic [1:0] INTENT_UNKNOWN = 2'd2;

  localparam logic [13:0] SCORE_FULL = 14'd10000;
  localparam logic [16:0] P_ONE      = 17'd65536;
  localparam logic [16:0] P_HALF     = 17'd32768;

  typedef struct packed {
    logic               op;
    logic [7:0]         coef_addr;
    logic [3:0]         feature_index;
    logic signed [31:0] value;
    logic               last;
  } slmc_in_t;

  typedef struct packed {
    logic [1:0]  intent;
    logic [13:0] left_score;
    logic [13:0] right_score;
    logic [13:0] confidence;
    logic        trained;
  } slmc_out_t;

  typedef struct packed {
    logic [13:0] threshold;
    logic        unknown_enable;
    logic        trained;
  } slmc_post_cfg_t;

  // sigmoid at k/2, q1.16, entries past the end are one
  function automatic logic [16:0] sig_tab(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd32768;
      5'd1:  v = 17'd40793;
      5'd2:  v = 17'd47911;
      5'd3:  v = 17'd53581;
      5'd4:  v = 17'd57724;
      5'd5:  v = 17'd60565;
      5'd6:  v = 17'd62428;
      5'd7:  v = 17'd63615;
      5'd8:  v = 17'd64357;
      5'd9:  v = 17'd64816;
      5'd10: v = 17'd65097;
      5'd11: v = 17'd65269;
      5'd12: v = 17'd65374;
      5'd13: v = 17'd65438;
      5'd14: v = 17'd65476;
      5'd15: v = 17'd65500;
      5'd16: v = 17'd65514;
      5'd17: v = 17'd65523;
      5'd18: v = 17'd65528;
      5'd19: v = 17'd65531;
      5'd20: v = 17'd65533;
      5'd21: v = 17'd65534;
      5'd22: v = 17'd65535;
      5'd23: v = 17'd65535;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- sv/standardized_linear_mlp_classifier_top.sv -----
// top level of the standardized linear / mlp classifier: sequencer and mac datapath
// depends on slmc_pkg, slmc_ram, slmc_div, slmc_post
//
// usage
// - input channel (in_valid/in_ready/in_data): op 0 writes one coefficient word,
//   op 1 writes one feature element; a feature transfer with last set starts a
//   classification and yields exactly one result transfer on the out channel
// - coefficient and feature transfers are accepted back to back while idle; a
//   classification holds in_ready low until its result is placed in the output register
// - a classification, with F features and H hidden units, first does standardization
//   of the F features one at a time (one restoring divider, one bit a cycle), then
//   the linear modes sum over F terms and the mlp mode runs H hidden units, all through
//   the single coefficient memory read port feeding one 32x32 multiplier
// - config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it only while no classification is in flight
// - reset (rst_n low, synchronous) clears the sequencer and restores register
//   defaults; coefficient and feature memories keep whatever they held
// - the output register holds a finished result while out_ready is low; the block
//   keeps taking coefficient and feature writes meanwhile, and a finished
//   classification waits until the register is free
module standardized_linear_mlp_classifier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  slmc_pkg::slmc_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output slmc_pkg::slmc_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import slmc_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_STD_M  = 4'd1;
  localparam logic [3:0] S_STD_S  = 4'd2;
  localparam logic [3:0] S_STD_D  = 4'd3;
  localparam logic [3:0] S_STD_W  = 4'd4;
  localparam logic [3:0] S_BIAS   = 4'd5;
  localparam logic [3:0] S_BIASW  = 4'd6;
  localparam logic [3:0] S_MAC_R  = 4'd7;
  localparam logic [3:0] S_MAC_M  = 4'd8;
  localparam logic [3:0] S_MAC_A  = 4'd9;
  localparam logic [3:0] S_END    = 4'd10;
  localparam logic [3:0] S_GAIN   = 4'd11;
  localparam logic [3:0] S_POST   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  // mac phases
  localparam logic [1:0] PH_LIN = 2'd0;
  localparam logic [1:0] PH_HID = 2'd1;
  localparam logic [1:0] PH_OUT = 2'd2;

  // configuration registers
  logic [1:0]  mode_r;
  logic [15:0] gain_r;
  logic [13:0] thresh_r;
  logic        unk_en_r;
  logic        trained_r;

  logic [3:0]          state_r, state_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [HID_AW-1:0]   j_r, j_nxt;
  logic [COEF_AW-1:0]  waddr_r, waddr_nxt;
  logic signed [63:0]  acc_r, acc_nxt;
  logic signed [63:0]  prod_r;
  logic signed [32:0]  diff_r;
  logic signed [48:0]  gx_r;
  logic signed [63:0]  x_r, x_nxt;
  logic                post_start_r, post_start_nxt;
  logic                out_valid_r;
  slmc_out_t           out_data_r;

  // memory ports
  logic                 coef_we;
  logic [COEF_AW-1:0]   coef_waddr, coef_raddr;
  logic [31:0]          coef_rdata;
  logic                 feat_we;
  logic [31:0]          feat_rdata;
  logic                 std_we;
  logic [31:0]          std_rdata;
  logic                 hid_we;
  logic [31:0]          hid_rdata;
  logic signed [31:0]   hid_wdata;

  logic                 div_start;
  logic                 div_done;
  logic signed [31:0]   div_quot;
  logic signed [31:0]   scale_eff;

  logic                 post_done;
  slmc_out_t            post_result;
  slmc_post_cfg_t       post_cfg;

  logic                 in_xfer;
  logic [KW-1:0]        k_last;
  logic [COEF_AW-1:0]   bias_addr, wbase_addr, stride;
  logic signed [31:0]   opnd;
  logic signed [31:0]   margin;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // config register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SVM;
      gain_r    <= 16'd256;
      thresh_r  <= '0;
      unk_en_r  <= 1'b0;
      trained_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:      mode_r    <= cfg_data[1:0];
        CFG_GAIN:      gain_r    <= cfg_data;
        CFG_THRESHOLD: thresh_r  <= cfg_data[13:0];
        CFG_UNK_EN:    unk_en_r  <= cfg_data[0];
        CFG_TRAINED:   trained_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per phase address bookkeeping
  always_comb begin
    k_last     = (phase_r == PH_OUT) ? KW'(HIDDEN_UNITS - 1) : KW'(FEATURES - 1);
    bias_addr  = COEF_AW'(A_SVM_B);
    wbase_addr = COEF_AW'(A_SVM_W);
    stride     = COEF_AW'(1);
    unique case (phase_r)
      PH_HID: begin
        bias_addr  = COEF_AW'(A_B0) + COEF_AW'(j_r);
        wbase_addr = COEF_AW'(A_W0) + COEF_AW'(j_r);
        stride     = COEF_AW'(HIDDEN_UNITS);
      end
      PH_OUT: begin
        bias_addr  = COEF_AW'(A_B1);
        wbase_addr = COEF_AW'(A_W1);
      end
      default: begin
        if (mode_r == MODE_LDA) begin
          bias_addr  = COEF_AW'(A_LDA_B);
          wbase_addr = COEF_AW'(A_LDA_W);
        end
      end
    endcase
  end

  // coefficient read address by sequencer state
  always_comb begin
    coef_raddr = waddr_r;
    unique case (state_r)
      S_STD_M: coef_raddr = COEF_AW'(A_MEAN) + COEF_AW'(k_r);
      S_STD_S: coef_raddr = COEF_AW'(A_SCALE) + COEF_AW'(k_r);
      S_BIAS:  coef_raddr = bias_addr;
      default: coef_raddr = waddr_r;
    endcase
  end

  assign coef_we    = in_xfer && (in_data.op == OP_COEF) &&
                      (32'(in_data.coef_addr) < COEF_DEPTH);
  assign coef_waddr = COEF_AW'(in_data.coef_addr);
  assign feat_we    = in_xfer && (in_data.op == OP_FEAT);

  // a zero scale word stands for one
  assign scale_eff = (coef_rdata == '0) ? 32'sd65536 : $signed(coef_rdata);
  assign div_start = (state_r == S_STD_D);
  assign std_we    = (state_r == S_STD_W) && div_done;

  assign opnd   = (phase_r == PH_OUT) ? $signed(hid_rdata) : $signed(std_rdata);
  assign margin = sat32(acc_r);

  // relu then saturate for hidden units
  assign hid_wdata = acc_r[63] ? 32'sd0 : sat32(acc_r);
  assign hid_we    = (state_r == S_END) && (phase_r == PH_HID);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    waddr_nxt      = waddr_r;
    acc_nxt        = acc_r;
    x_nxt          = x_r;
    post_start_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.op == OP_FEAT) && in_data.last) begin
          state_nxt = S_STD_M;
          k_nxt     = '0;
        end
      end
      S_STD_M: state_nxt = S_STD_S;
      S_STD_S: state_nxt = S_STD_D;
      S_STD_D: state_nxt = S_STD_W;
      S_STD_W: begin
        if (div_done) begin
          if (k_r == KW'(FEATURES - 1)) begin
            state_nxt = S_BIAS;
            phase_nxt = (mode_r == MODE_MLP) ? PH_HID : PH_LIN;
            j_nxt     = '0;
          end else begin
            state_nxt = S_STD_M;
            k_nxt     = k_r + KW'(1);
          end
        end
      end
      S_BIAS: state_nxt = S_BIASW;
      S_BIASW: begin
        acc_nxt   = 64'($signed(coef_rdata));
        k_nxt     = '0;
        waddr_nxt = wbase_addr;
        state_nxt = S_MAC_R;
      end
      S_MAC_R: begin
        state_nxt = S_MAC_M;
      end
      S_MAC_M: begin
        waddr_nxt = waddr_r + stride;
        state_nxt = S_MAC_A;
      end
      S_MAC_A: begin
        // floor of the q16.16 product
        acc_nxt = acc_r + (prod_r >>> 16);
        if (k_r == k_last) begin
          state_nxt = S_END;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_MAC_R;
        end
      end
      S_END: begin
        unique case (phase_r)
          PH_HID: begin
            state_nxt = S_BIAS;
            if (j_r == HID_AW'(HIDDEN_UNITS - 1)) begin
              phase_nxt = PH_OUT;
            end else begin
              j_nxt = j_r + HID_AW'(1);
            end
          end
          PH_OUT: begin
            x_nxt          = acc_r;
            post_start_nxt = 1'b1;
            state_nxt      = S_POST;
          end
          default: state_nxt = S_GAIN;
        endcase
      end
      S_GAIN: begin
        x_nxt          = $signed({{15{gx_r[48]}}, gx_r}) >>> 8;
        post_start_nxt = 1'b1;
        state_nxt      = S_POST;
      end
      S_POST: begin
        if (post_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_LIN;
      k_r          <= '0;
      j_r          <= '0;
      post_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      acc_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      k_r          <= k_nxt;
      j_r          <= j_nxt;
      post_start_r <= post_start_nxt;
      acc_r        <= acc_nxt;
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    waddr_r <= waddr_nxt;
    x_r     <= x_nxt;
    if (state_r == S_STD_S) begin
      diff_r <= 33'($signed(feat_rdata)) - 33'($signed(coef_rdata));
    end
    if (state_r == S_MAC_M) begin
      prod_r <= $signed(coef_rdata) * opnd;
    end
    if (state_r == S_END) begin
      gx_r <= margin * $signed({1'b0, gain_r});
    end
    if ((state_r == S_OUT) && out_free) begin
      out_data_r <= post_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign post_cfg.threshold      = thresh_r;
  assign post_cfg.unknown_enable = unk_en_r;
  assign post_cfg.trained        = trained_r;

  slmc_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_data.value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  slmc_ram #(.WIDTH(32), .DEPTH(FEAT_DEPTH)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (in_data.feature_index),
    .wdata (in_data.value),
    .raddr (FEAT_AW'(k_r)),
    .rdata (feat_rdata)
  );

  slmc_ram #(.WIDTH(32), .DEPTH(FEATURES)) u_std_ram (
    .clk   (clk),
    .we    (std_we),
    .waddr (STD_AW'(k_r)),
    .wdata (div_quot),
    .raddr (STD_AW'(k_r)),
    .rdata (std_rdata)
  );

  slmc_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_hid_ram (
    .clk   (clk),
    .we    (hid_we),
    .waddr (j_r),
    .wdata (hid_wdata),
    .raddr (HID_AW'(k_r)),
    .rdata (hid_rdata)
  );

  slmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({diff_r, 16'd0}),
    .den   (scale_eff),
    .done  (div_done),
    .quot  (div_quot)
  );

  slmc_post u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (post_start_r),
    .x      (x_r),
    .cfg    (post_cfg),
    .done   (post_done),
    .result (post_result)
  );

endmodule

// ----- sv/slmc_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module slmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/slmc_div.sv -----
// standardization divider: ((x - mean) << 16) / scale, one quotient bit per cycle
// depends on slmc_pkg
module slmc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [48:0]  num,
  input  logic signed [31:0]  den,
  output logic                done,
  output logic signed [31:0]  quot
);
  import slmc_pkg::*;

  logic [48:0] nq_r, nq_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dmag_r, dmag_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;
  logic        done_r, done_nxt;
  logic signed [31:0] quot_r, quot_nxt;
  logic [32:0] rem_sh;
  logic signed [63:0] qs;

  always_comb begin
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    rem_sh   = {rem_r[31:0], nq_r[48]};
    qs       = neg_r ? -$signed({15'd0, nq_r}) : $signed({15'd0, nq_r});
    if (start) begin
      nq_nxt   = num[48] ? 49'(-num) : 49'(num);
      dmag_nxt = den[31] ? 32'(-den) : 32'(den);
      neg_nxt  = num[48] ^ den[31];
      rem_nxt  = '0;
      cnt_nxt  = 6'd49;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dmag_r}) begin
        rem_nxt = rem_sh - {1'b0, dmag_r};
        nq_nxt  = {nq_r[47:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        nq_nxt  = {nq_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      quot_nxt = sat32(qs);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r   <= nq_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- sv/slmc_post.sv -----
// sigmoid by table interpolation, then scores, confidence and intent
// depends on slmc_pkg
module slmc_post (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [63:0]          x,
  input  slmc_pkg::slmc_post_cfg_t    cfg,
  output logic                        done,
  output slmc_pkg::slmc_out_t         result
);
  import slmc_pkg::*;

  logic        v1_r, v2_r, v3_r, done_r;
  logic        neg1_r, sat1_r;
  logic [16:0] lo1_r;
  logic [12:0] diff1_r;
  logic [14:0] frac1_r;
  logic [16:0] p2_r;
  logic [13:0] sr3_r;
  logic        right3_r;
  slmc_out_t   result_r;

  logic [63:0] a;
  logic [4:0]  idx;
  logic [16:0] lo, hi;
  logic [28:0] prodi;
  logic [16:0] pos;
  logic [30:0] t;
  logic [14:0] sr;
  logic [13:0] sr_c, sl, conf;

  always_comb begin
    a     = x[63] ? 64'(-x) : 64'(x);
    idx   = a[19:15];
    lo    = sig_tab(idx);
    hi    = sig_tab(idx + 5'd1);
    prodi = 29'(diff1_r) * 29'(frac1_r) + 29'd16384;
    pos   = sat1_r ? P_ONE : lo1_r + 17'(prodi >> 15);
    t     = 31'(p2_r) * 31'(SCORE_FULL) + 31'd32768;
    sr    = t[30:16];
    sr_c  = (sr > 15'(SCORE_FULL)) ? SCORE_FULL : sr[13:0];
    sl    = SCORE_FULL - sr3_r;
    conf  = (sl > sr3_r) ? sl - sr3_r : sr3_r - sl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg1_r  <= x[63];
      sat1_r  <= (a[63:20] != '0) || (idx >= 5'd24);
      lo1_r   <= lo;
      diff1_r <= 13'(hi - lo);
      frac1_r <= a[14:0];
    end
    if (v1_r) begin
      p2_r <= neg1_r ? P_ONE - pos : pos;
    end
    if (v2_r) begin
      sr3_r    <= sr_c;
      right3_r <= (p2_r >= P_HALF);
    end
    if (v3_r) begin
      result_r.right_score <= sr3_r;
      result_r.left_score  <= sl;
      result_r.confidence  <= conf;
      result_r.trained     <= cfg.trained;
      if (cfg.unknown_enable && (conf < cfg.threshold)) begin
        result_r.intent <= INTENT_UNKNOWN;
      end else begin
        result_r.intent <= right3_r ? INTENT_RIGHT : INTENT_LEFT;
      end
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

// ----- bench/slmc_scoreboard.sv -----
// checker for the standardized linear / mlp classifier: mirrors the datapath and
// compares every result transfer; depends on slmc_pkg
`timescale 1ns / 100ps

module slmc_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  slmc_pkg::slmc_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  slmc_pkg::slmc_out_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [slmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              results_pending
);
  import slmc_pkg::*;

  localparam int unsigned SIG_LUT [0:24] = '{
    32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
    64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514, 65523,
    65528, 65531, 65533, 65534, 65535, 65535, 65536
  };

  logic signed [31:0] coef_mem [COEF_DEPTH];
  logic signed [31:0] feat_mem [FEAT_DEPTH];
  logic [1:0]         mode_r;
  logic [15:0]        gain_r;
  logic [13:0]        thresh_r;
  logic               unk_en_r;
  logic               trained_r;
  slmc_out_t          score_q [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint standardized(int i);
    longint diff, sc;
    diff = longint'(feat_mem[i]) - longint'(coef_mem[A_MEAN + i]);
    sc   = longint'(coef_mem[A_SCALE + i]);
    if (sc == 0) sc = 65536;  // zero scale counts as one
    return clamp32((diff * 65536) / sc);
  endfunction

  function automatic longint linear_sum(int wbase, int baddr);
    longint acc;
    acc = longint'(coef_mem[baddr]);
    for (int i = 0; i < FEATURES; i++)
      acc += (longint'(coef_mem[wbase + i]) * standardized(i)) >>> 16;
    return clamp32(acc);
  endfunction

  function automatic longint mlp_sum();
    longint acc, z;
    longint hid [HIDDEN_UNITS];
    longint xs [FEATURES];
    for (int i = 0; i < FEATURES; i++) xs[i] = standardized(i);
    for (int j = 0; j < HIDDEN_UNITS; j++) begin
      acc = longint'(coef_mem[A_B0 + j]);
      for (int i = 0; i < FEATURES; i++)
        acc += (xs[i] * longint'(coef_mem[A_W0 + i * HIDDEN_UNITS + j])) >>> 16;
      if (acc < 0) acc = 0;
      hid[j] = clamp32(acc);
    end
    z = longint'(coef_mem[A_B1]);
    for (int j = 0; j < HIDDEN_UNITS; j++)
      z += (hid[j] * longint'(coef_mem[A_W1 + j])) >>> 16;
    return z;
  endfunction

  function automatic longint sig_half(longint a);
    longint idx, frac, lo, hi;
    idx = a >>> 15;
    if (idx >= 24) return 65536;
    frac = a & 64'h7FFF;
    lo = SIG_LUT[idx];
    hi = SIG_LUT[idx + 1];
    return lo + (((hi - lo) * frac + 16384) >>> 15);
  endfunction

  function automatic slmc_out_t classify();
    slmc_out_t r;
    longint x, p, sr, sl, conf;
    if (mode_r == MODE_MLP) x = mlp_sum();
    else if (mode_r == MODE_LDA) x = (linear_sum(A_LDA_W, A_LDA_B) * longint'(gain_r)) >>> 8;
    else x = (linear_sum(A_SVM_W, A_SVM_B) * longint'(gain_r)) >>> 8;
    p  = (x >= 0) ? sig_half(x) : 65536 - sig_half(-x);
    sr = (p * 10000 + 32768) >>> 16;
    if (sr > 10000) sr = 10000;
    sl = 10000 - sr;
    conf = (sl > sr) ? sl - sr : sr - sl;
    r.intent = (p >= 32768) ? INTENT_RIGHT : INTENT_LEFT;
    if (unk_en_r && conf < thresh_r) r.intent = INTENT_UNKNOWN;
    r.left_score  = sl[13:0];
    r.right_score = sr[13:0];
    r.confidence  = conf[13:0];
    r.trained     = trained_r;
    return r;
  endfunction

  always @(posedge clk) begin
    slmc_out_t want;
    if (!rst_n) begin
      mode_r    <= MODE_SVM;
      gain_r    <= 16'd256;
      thresh_r  <= '0;
      unk_en_r  <= 1'b0;
      trained_r <= 1'b1;
      mismatch_count = 0;
      score_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:      mode_r    <= cfg_data[1:0];
          CFG_GAIN:      gain_r    <= cfg_data;
          CFG_THRESHOLD: thresh_r  <= cfg_data[13:0];
          CFG_UNK_EN:    unk_en_r  <= cfg_data[0];
          CFG_TRAINED:   trained_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_COEF) begin
          coef_mem[in_data.coef_addr] = in_data.value;
        end else begin
          feat_mem[in_data.feature_index] = in_data.value;
          if (in_data.last) score_q.push_back(classify());
        end
      end
      if (out_valid && out_ready) begin
        if (score_q.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatch_count++;
        end else begin
          want = score_q.pop_front();
          if (out_data.intent !== want.intent) begin
            $error("intent: expected %0d, got %0d", want.intent, out_data.intent);
            mismatch_count++;
          end
          if (out_data.left_score !== want.left_score) begin
            $error("left_score: expected %0d, got %0d", want.left_score, out_data.left_score);
            mismatch_count++;
          end
          if (out_data.right_score !== want.right_score) begin
            $error("right_score: expected %0d, got %0d",
                   want.right_score, out_data.right_score);
            mismatch_count++;
          end
          if (out_data.confidence !== want.confidence) begin
            $error("confidence: expected %0d, got %0d", want.confidence, out_data.confidence);
            mismatch_count++;
          end
          if (out_data.trained !== want.trained) begin
            $error("trained: expected %0d, got %0d", want.trained, out_data.trained);
            mismatch_count++;
          end
        end
      end
    end
    results_pending <= score_q.size();
  end

endmodule

// ----- bench/standardized_linear_mlp_classifier_top_tb.sv -----
// testbench top for the standardized linear / mlp classifier: clock, reset,
// stimulus and verdict; depends on slmc_pkg, slmc_scoreboard and the block
`timescale 1ns / 100ps

module standardized_linear_mlp_classifier_top_tb;
  import slmc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  slmc_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  slmc_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatch_count;
  int                    results_pending;

  // stimulus asks the receiver for one long hold-off
  logic                  long_hold_req = 1'b0;

  // burst shaping for the sender
  int                    burst_left = 0;

  standardized_linear_mlp_classifier_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slmc_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_pending(results_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: segments of steady, random and sparse ready, plus one long hold-off
  initial begin
    bit hold_done;
    int seg_kind, seg_len;
    hold_done = 1'b0;
    forever begin
      seg_kind = $urandom_range(0, 2);
      seg_len  = $urandom_range(20, 300);
      for (int c = 0; c < seg_len; c++) begin
        @(posedge clk);
        if (long_hold_req && !hold_done) begin
          // out register fills, then the block stalls the input side
          out_ready <= 1'b0;
          repeat (4000) @(posedge clk);
          hold_done = 1'b1;
        end
        case (seg_kind)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic slmc_in_t make_item(logic op, int addr, int idx,
                                         logic [31:0] val, logic last);
    slmc_in_t it;
    it.op            = op;
    it.coef_addr     = addr[7:0];
    it.feature_index = idx[3:0];
    it.value         = val;
    it.last          = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_span(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // plausible coefficient word for a given address
  function automatic logic [31:0] coef_word(int addr);
    int mag;
    if (addr < A_SCALE) return rand_span(1 << 18);
    if (addr < A_SVM_W) begin
      mag = $urandom_range(1 << 14, 1 << 18);
      return ($urandom_range(0, 1) != 0) ? mag : -mag;
    end
    return rand_span(1 << 16);
  endfunction

  // one transfer on the input channel, with bursts and gaps between them
  task automatic push_item(slmc_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      in_valid <= 1'b0;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int mode, int gain, int thresh, int unk, int trained);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_THRESHOLD, thresh);
    write_reg(CFG_UNK_EN, unk);
    write_reg(CFG_TRAINED, trained);
  endtask

  initial begin
    logic [31:0] v;
    int          roll, addr, idx;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(MODE_SVM, 256, 0, 0, 1);

    // full coefficient image so no classification reads an unwritten word
    for (int a = 0; a <= A_B1; a++) begin
      v = coef_word(a);
      if (a == A_SCALE + 3) v = '0;  // zero scale treated as one
      push_item(make_item(OP_COEF, a, 0, v, 1'b0));
    end

    // directed: extreme features, first classification
    push_item(make_item(OP_FEAT, 0, 0, 32'h7FFFFFFF, 1'b0));
    push_item(make_item(OP_FEAT, 0, 1, 32'h80000000, 1'b0));
    push_item(make_item(OP_FEAT, 0, 2, 32'h00000000, 1'b0));
    push_item(make_item(OP_FEAT, 0, 3, 32'hFFFFFFFF, 1'b0));
    for (int i = 4; i < FEATURES - 1; i++)
      push_item(make_item(OP_FEAT, 0, i, rand_span(1 << 18), 1'b0));
    push_item(make_item(OP_FEAT, 0, FEATURES - 1, 32'h00010000, 1'b1));
    // last on a coefficient write gives nothing; unused addresses are harmless
    push_item(make_item(OP_COEF, 255, 0, 32'hFFFFFFFF, 1'b1));
    push_item(make_item(OP_COEF, A_B1 + 1, 0, 32'h80000000, 1'b0));
    // unused feature slot, still triggers a classification
    push_item(make_item(OP_FEAT, 0, 15, 32'h55555555, 1'b1));
    wait_idle();

    // each model mode, including the unused code; unknown intent enabled for lda and mlp
    set_regs(MODE_LDA, 65535, 10000, 1, 0);
    push_item(make_item(OP_FEAT, 0, 0, 32'h00008000, 1'b1));
    wait_idle();
    set_regs(MODE_MLP, 0, 0, 1, 1);
    push_item(make_item(OP_FEAT, 0, 1, 32'hFFFF0000, 1'b1));
    push_item(make_item(OP_FEAT, 0, 2, 32'h00030000, 1'b1));
    wait_idle();
    set_regs(MODE_RSVD, 1, 5000, 0, 1);
    push_item(make_item(OP_FEAT, 0, 5, 32'h000A0000, 1'b1));
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_regs(MODE_SVM, $urandom_range(64, 1024), $urandom_range(0, 10000), 1, 1);
        1:       set_regs(MODE_MLP, 256, $urandom_range(0, 3000), 1, 0);
        2:       set_regs(MODE_LDA, 65535, 10000, $urandom_range(0, 1), 1);
        3:       set_regs(MODE_MLP, 0, 0, 0, 1);
        default: set_regs($urandom_range(0, 3), $urandom_range(0, 65535),
                          $urandom_range(0, 10000), $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      for (int n = 0; n < 90; n++) begin
        if (ph == 2 && n == 30) long_hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          idx = $urandom_range(0, 15);
          v = ($urandom_range(0, 3) == 0) ? $urandom() : rand_span(1 << 19);
          push_item(make_item(OP_FEAT, $urandom_range(0, 255), idx, v,
                              $urandom_range(0, 7) == 0));
        end else if (roll < 90) begin
          addr = $urandom_range(0, A_B1);
          push_item(make_item(OP_COEF, addr, $urandom_range(0, 15), coef_word(addr),
                              $urandom_range(0, 1)));
        end else begin
          // raw words anywhere in the map, zero scales included
          v = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom();
          push_item(make_item(OP_COEF, $urandom_range(0, 255), $urandom_range(0, 15), v,
                              $urandom_range(0, 1)));
        end
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/slmc_pkg.sv
sv/slmc_ram.sv
sv/slmc_div.sv
sv/slmc_post.sv
sv/standardized_linear_mlp_classifier_top.sv
bench/slmc_scoreboard.sv
bench/standardized_linear_mlp_classifier_top_tb.sv
